// ===== design/lzsst_pkg.sv =====
`timescale 1ns / 1ps

package lzsst_pkg;

  localparam int WindowSize = 4096;
  localparam int MaxMatch   = 16;
  localparam int MinMatch   = 3;
  localparam int FillStart  = WindowSize - MaxMatch;
  localparam int WinDepth   = WindowSize + MaxMatch;
  localparam int RootCount  = 256;
  localparam int GroupBytes = 16;

  localparam logic [12:0] NilNode  = 13'h1FFF;
  localparam logic [13:0] NoLink   = 14'h3FFF;
  localparam logic [7:0]  FillByte = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
  } out_item_t;

  typedef enum logic [1:0] {
    TK_LIT   = 2'd0,
    TK_MATCH = 2'd1,
    TK_CLOSE = 2'd2
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } tok_cmd_t;

endpackage

// ===== design/lzsst_group.sv =====
`timescale 1ns / 1ps

module lzsst_group (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  lzsst_pkg::tok_cmd_t  cmd_i,
  output logic                 cmd_ready_o,
  output logic                 out_valid_o,
  output lzsst_pkg::out_item_t out_data_o,
  input  logic                 out_stall_i
);

  typedef enum logic [2:0] {
    G_IDLE  = 3'b001,
    G_FLUSH = 3'b010,
    G_FIN   = 3'b100
  } grp_state_e;

  grp_state_e state_q, state_d;

  logic [7:0] data_q [lzsst_pkg::GroupBytes];
  logic       dwe0, dwe1;
  logic [3:0] dwa0, dwa1;
  logic [7:0] dwd0, dwd1;

  logic [7:0] flag_q, flag_d;
  logic [4:0] fill_q, fill_d;
  logic [2:0] tok_q, tok_d;
  logic [4:0] k_q, k_d;
  logic       fin_q, fin_d;
  logic       eos_q, eos_d;
  logic       held_v_q, held_v_d;
  logic [7:0] held_q, held_d;
  logic       out_v_q, out_v_d;
  lzsst_pkg::out_item_t out_q, out_d;

  logic       out_free;
  logic [7:0] ebyte;
  logic [4:0] kprev;

  assign cmd_ready_o = (state_q == G_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_v_q || !out_stall_i;
  assign kprev       = k_q - 5'd1;
  assign ebyte       = (k_q == 5'd0) ? flag_q : data_q[kprev[3:0]];

  always_comb begin
    state_d  = state_q;
    flag_d   = flag_q;
    fill_d   = fill_q;
    tok_d    = tok_q;
    k_d      = k_q;
    fin_d    = fin_q;
    eos_d    = eos_q;
    held_v_d = held_v_q;
    held_d   = held_q;
    out_v_d  = out_v_q && out_stall_i;
    out_d    = out_q;
    dwe0 = 1'b0;
    dwe1 = 1'b0;
    dwa0 = fill_q[3:0];
    dwa1 = fill_q[3:0] + 4'd1;
    dwd0 = cmd_i.b0;
    dwd1 = cmd_i.b1;

    unique case (state_q)
      G_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            lzsst_pkg::TK_LIT, lzsst_pkg::TK_MATCH: begin
              dwe0 = 1'b1;
              if (cmd_i.kind == lzsst_pkg::TK_LIT) begin
                flag_d = flag_q | (8'd1 << tok_q);
                fill_d = fill_q + 5'd1;
              end else begin
                dwe1   = 1'b1;
                fill_d = fill_q + 5'd2;
              end
              tok_d = tok_q + 3'd1;
              if (tok_q == 3'd7) begin
                k_d     = '0;
                fin_d   = 1'b0;
                state_d = G_FLUSH;
              end
            end
            lzsst_pkg::TK_CLOSE: begin
              eos_d = cmd_i.last;
              if (cmd_i.last && fill_q != 5'd0) begin
                k_d     = '0;
                fin_d   = 1'b1;
                state_d = G_FLUSH;
              end else begin
                state_d = G_FIN;
              end
            end
            default: state_d = G_IDLE;
          endcase
        end
      end
      G_FLUSH: begin
        // one byte stays held back so the last one of a step can be marked
        if (!held_v_q || out_free) begin
          if (held_v_q) begin
            out_v_d = 1'b1;
            out_d   = '{out_byte: held_q, run_end: 1'b0, stream_end: 1'b0};
          end
          held_d   = ebyte;
          held_v_d = 1'b1;
          k_d      = k_q + 5'd1;
          if (k_q == fill_q) begin
            flag_d  = '0;
            fill_d  = '0;
            tok_d   = '0;
            state_d = fin_q ? G_FIN : G_IDLE;
          end
        end
      end
      G_FIN: begin
        if (!held_v_q) begin
          state_d = G_IDLE;
        end else if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = '{out_byte: held_q, run_end: 1'b1, stream_end: eos_q};
          held_v_d = 1'b0;
          state_d  = G_IDLE;
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= G_IDLE;
      flag_q   <= '0;
      fill_q   <= '0;
      tok_q    <= '0;
      k_q      <= '0;
      fin_q    <= 1'b0;
      eos_q    <= 1'b0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      flag_q   <= flag_d;
      fill_q   <= fill_d;
      tok_q    <= tok_d;
      k_q      <= k_d;
      fin_q    <= fin_d;
      eos_q    <= eos_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
    out_q  <= out_d;
    if (dwe0) data_q[dwa0] <= dwd0;
    if (dwe1) data_q[dwa1] <= dwd1;
  end

endmodule

// ===== design/lzsst_core.sv =====
`timescale 1ns / 1ps

module lzsst_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  lzsst_pkg::in_item_t in_data_i,
  output logic                in_ready_o,
  output logic                cmd_valid_o,
  output lzsst_pkg::tok_cmd_t cmd_o,
  input  logic                cmd_ready_i
);

  typedef enum logic [26:0] {
    ST_CLEAR  = 27'd1 << 0,
    ST_IDLE   = 27'd1 << 1,
    ST_RM0    = 27'd1 << 2,
    ST_RM1    = 27'd1 << 3,
    ST_RM2    = 27'd1 << 4,
    ST_WALK   = 27'd1 << 5,
    ST_SUC0   = 27'd1 << 6,
    ST_SUC1   = 27'd1 << 7,
    ST_SUC2   = 27'd1 << 8,
    ST_SUC3   = 27'd1 << 9,
    ST_RMR    = 27'd1 << 10,
    ST_LINK   = 27'd1 << 11,
    ST_UNLINK = 27'd1 << 12,
    ST_INS0   = 27'd1 << 13,
    ST_INS1   = 27'd1 << 14,
    ST_GET    = 27'd1 << 15,
    ST_JCHK   = 27'd1 << 16,
    ST_CMP0   = 27'd1 << 17,
    ST_CMP1   = 27'd1 << 18,
    ST_DEC    = 27'd1 << 19,
    ST_EQ1    = 27'd1 << 20,
    ST_EQ2    = 27'd1 << 21,
    ST_INSEND = 27'd1 << 22,
    ST_POST   = 27'd1 << 23,
    ST_TOK    = 27'd1 << 24,
    ST_NEXT   = 27'd1 << 25,
    ST_CLOSE  = 27'd1 << 26
  } core_state_e;

  core_state_e state_q, state_d;

  // memories
  logic [7:0]  wb_mem [lzsst_pkg::WinDepth];
  logic [13:0] pl_mem [lzsst_pkg::WindowSize];
  logic [12:0] lc_mem [lzsst_pkg::WindowSize];
  logic [12:0] rc_mem [lzsst_pkg::WindowSize];
  logic [12:0] rt_mem [lzsst_pkg::RootCount];

  logic        wb_we;
  logic [12:0] wb_wa, wb_ra0, wb_ra1;
  logic [7:0]  wb_wd, wb_rd0_q, wb_rd1_q;
  logic        pl_we;
  logic [11:0] pl_wa, pl_ra;
  logic [13:0] pl_wd, pl_rd_q;
  logic        lc_we, rc_we;
  logic [11:0] lc_wa, lc_ra, rc_wa, rc_ra;
  logic [12:0] lc_wd, rc_wd, lc_rd_q, rc_rd_q;
  logic        rt_we;
  logic [7:0]  rt_wa, rt_ra;
  logic [12:0] rt_wd, rt_rd_q;

  // tree link writes: slot by link code, parent by node
  logic        sw_en, sp_en;
  logic [13:0] sw_code, sp_code;
  logic [12:0] sw_val, sp_node;

  // control state
  logic [11:0]       clr_q, clr_d;
  logic              filling_q, filling_d;
  logic [4:0]        look_q, look_d;
  logic [11:0]       wi_q, wi_d;
  logic [4:0]        run_q, run_d;
  logic signed [6:0] pend_q, pend_d;
  logic              eof_q, eof_d;
  logic              end_q, end_d;

  // working registers
  logic [7:0]  byte_q, byte_d;
  logic [4:0]  g_q, g_d;
  logic [11:0] z_q, z_d;
  logic [13:0] zpar_q, zpar_d;
  logic [12:0] zl_q, zl_d, zr_q, zr_d;
  logic [12:0] j_q, j_d;
  logic        moved_q, moved_d;
  logic [13:0] jp_q, jp_d;
  logic [12:0] jl_q, jl_d;
  logic [13:0] slot_q, slot_d;
  logic [4:0]  k_q, k_d, l_q, l_d, n_q, n_d;
  logic [11:0] jn_q, jn_d;
  logic        cneg_q, cneg_d, cpos_q, cpos_d;
  logic [4:0]  match_q, match_d;
  logic [11:0] mpos_q, mpos_d;
  logic        lit_q, lit_d;

  logic [12:0]       pos_p;
  logic [12:0]       slot_data;
  logic [4:0]        look_n, run_n;
  logic signed [6:0] pend1, pend2;
  logic              take;

  assign pos_p     = {1'b0, wi_q} + 13'(lzsst_pkg::MaxMatch);
  assign slot_data = slot_q[13] ? rt_rd_q : (slot_q[12] ? rc_rd_q : lc_rd_q);
  assign look_n    = look_q + 5'd1;
  assign run_n     = (eof_q && run_q != 5'd0) ? run_q - 5'd1 : run_q;
  assign pend1     = eof_q ? pend_q - 7'sd1 : pend_q;
  assign pend2     = pend1 + 7'sd1;
  assign take      = pend1 >= $signed({2'b00, run_n});
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    filling_d = filling_q;
    look_d    = look_q;
    wi_d      = wi_q;
    run_d     = run_q;
    pend_d    = pend_q;
    eof_d     = eof_q;
    end_d     = end_q;
    byte_d    = byte_q;
    g_d       = g_q;
    z_d       = z_q;
    zpar_d    = zpar_q;
    zl_d      = zl_q;
    zr_d      = zr_q;
    j_d       = j_q;
    moved_d   = moved_q;
    jp_d      = jp_q;
    jl_d      = jl_q;
    slot_d    = slot_q;
    k_d       = k_q;
    l_d       = l_q;
    n_d       = n_q;
    jn_d      = jn_q;
    cneg_d    = cneg_q;
    cpos_d    = cpos_q;
    match_d   = match_q;
    mpos_d    = mpos_q;
    lit_d     = lit_q;

    wb_we  = 1'b0;
    wb_wa  = pos_p;
    wb_wd  = byte_q;
    wb_ra0 = {1'b0, wi_q};
    wb_ra1 = {1'b0, wi_q};
    pl_we  = 1'b0;
    pl_wa  = '0;
    pl_wd  = lzsst_pkg::NoLink;
    pl_ra  = z_q;
    lc_we  = 1'b0;
    lc_wa  = wi_q;
    lc_wd  = lzsst_pkg::NilNode;
    lc_ra  = z_q;
    rc_we  = 1'b0;
    rc_wa  = wi_q;
    rc_wd  = lzsst_pkg::NilNode;
    rc_ra  = z_q;
    rt_we  = 1'b0;
    rt_wa  = clr_q[7:0];
    rt_wd  = lzsst_pkg::NilNode;
    rt_ra  = slot_q[7:0];
    sw_en  = 1'b0;
    sw_code = slot_q;
    sw_val  = {1'b0, wi_q};
    sp_en   = 1'b0;
    sp_node = {1'b0, wi_q};
    sp_code = slot_q;

    cmd_valid_o = 1'b0;
    cmd_o = '{kind: lzsst_pkg::TK_CLOSE, b0: wb_rd0_q, b1: '0, last: end_q};

    unique case (state_q)
      ST_CLEAR: begin
        sp_en   = 1'b1;
        sp_node = {1'b0, clr_q};
        sp_code = lzsst_pkg::NoLink;
        rt_we   = (clr_q < 12'(lzsst_pkg::RootCount));
        clr_d   = clr_q + 12'd1;
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_data_i.data_byte;
          end_d  = in_data_i.end_of_data;
          eof_d  = 1'b0;
          if (filling_q) begin
            wb_we  = 1'b1;
            wb_wa  = 13'(lzsst_pkg::FillStart) + {8'b0, look_q};
            wb_wd  = in_data_i.data_byte;
            look_d = look_n;
            if (in_data_i.end_of_data || look_n >= 5'(lzsst_pkg::MaxMatch)) begin
              filling_d = 1'b0;
              run_d     = look_n;
              pend_d    = $signed({2'b00, look_n});
              wi_d      = 12'(lzsst_pkg::FillStart);
            end
            if (in_data_i.end_of_data) begin
              eof_d   = 1'b1;
              g_d     = '0;
              byte_d  = lzsst_pkg::FillByte;
              state_d = ST_RM0;
            end else begin
              state_d = ST_CLOSE;
            end
          end else begin
            state_d = ST_RM0;
          end
        end
      end
      // drop the node that leaves the window, store the new byte
      ST_RM0: begin
        wb_we   = 1'b1;
        pl_ra   = pos_p[11:0];
        z_d     = pos_p[11:0];
        state_d = ST_RM1;
      end
      ST_RM1: begin
        wb_we = pos_p[12];
        wb_wa = {1'b0, pos_p[11:0]};
        if (pl_rd_q == lzsst_pkg::NoLink) begin
          state_d = ST_INS0;
        end else begin
          zpar_d  = pl_rd_q;
          state_d = ST_RM2;
        end
      end
      ST_RM2: begin
        zl_d = lc_rd_q;
        zr_d = rc_rd_q;
        if (rc_rd_q[12]) begin
          j_d     = lc_rd_q;
          state_d = ST_LINK;
        end else if (lc_rd_q[12]) begin
          j_d     = rc_rd_q;
          state_d = ST_LINK;
        end else begin
          j_d     = lc_rd_q;
          moved_d = 1'b0;
          rc_ra   = lc_rd_q[11:0];
          state_d = ST_WALK;
        end
      end
      // rightmost node of the left subtree
      ST_WALK: begin
        if (!rc_rd_q[12]) begin
          j_d     = rc_rd_q;
          moved_d = 1'b1;
          rc_ra   = rc_rd_q[11:0];
        end else if (moved_q) begin
          state_d = ST_SUC0;
        end else begin
          state_d = ST_RMR;
        end
      end
      ST_SUC0: begin
        pl_ra   = j_q[11:0];
        lc_ra   = j_q[11:0];
        state_d = ST_SUC1;
      end
      ST_SUC1: begin
        jp_d    = pl_rd_q;
        jl_d    = lc_rd_q;
        sw_en   = 1'b1;
        sw_code = pl_rd_q;
        sw_val  = lc_rd_q;
        state_d = ST_SUC2;
      end
      ST_SUC2: begin
        sp_en   = 1'b1;
        sp_node = jl_q;
        sp_code = jp_q;
        lc_we   = 1'b1;
        lc_wa   = j_q[11:0];
        lc_wd   = zl_q;
        state_d = ST_SUC3;
      end
      ST_SUC3: begin
        sp_en   = 1'b1;
        sp_node = zl_q;
        sp_code = {2'b00, j_q[11:0]};
        state_d = ST_RMR;
      end
      ST_RMR: begin
        rc_we   = 1'b1;
        rc_wa   = j_q[11:0];
        rc_wd   = zr_q;
        sp_en   = 1'b1;
        sp_node = zr_q;
        sp_code = {2'b01, j_q[11:0]};
        state_d = ST_LINK;
      end
      ST_LINK: begin
        sp_en   = 1'b1;
        sp_node = j_q;
        sp_code = zpar_q;
        sw_en   = 1'b1;
        sw_code = zpar_q;
        sw_val  = j_q;
        state_d = ST_UNLINK;
      end
      ST_UNLINK: begin
        sp_en   = 1'b1;
        sp_node = {1'b0, z_q};
        sp_code = lzsst_pkg::NoLink;
        state_d = ST_INS0;
      end
      // insert the string at the coding position, track the longest match
      ST_INS0: begin
        lc_we   = 1'b1;
        rc_we   = 1'b1;
        k_d     = 5'd1;
        l_d     = 5'd1;
        match_d = 5'(lzsst_pkg::MinMatch - 1);
        state_d = ST_INS1;
      end
      ST_INS1: begin
        slot_d  = {6'b100000, wb_rd0_q};
        state_d = ST_GET;
      end
      ST_GET: begin
        lc_ra   = slot_q[11:0];
        rc_ra   = slot_q[11:0];
        state_d = ST_JCHK;
      end
      ST_JCHK: begin
        if (slot_data[12]) begin
          state_d = ST_INSEND;
        end else begin
          jn_d    = slot_data[11:0];
          n_d     = (k_q < l_q) ? k_q : l_q;
          cneg_d  = 1'b0;
          cpos_d  = 1'b0;
          state_d = ST_CMP0;
        end
      end
      ST_CMP0: begin
        wb_ra0 = {1'b0, jn_q} + {8'b0, n_q};
        wb_ra1 = {1'b0, wi_q} + {8'b0, n_q};
        state_d = (n_q < run_q) ? ST_CMP1 : ST_DEC;
      end
      ST_CMP1: begin
        if ($signed(wb_rd0_q) < $signed(wb_rd1_q)) begin
          cneg_d  = 1'b1;
          state_d = ST_DEC;
        end else if ($signed(wb_rd0_q) > $signed(wb_rd1_q)) begin
          cpos_d  = 1'b1;
          state_d = ST_DEC;
        end else begin
          n_d     = n_q + 5'd1;
          state_d = ST_CMP0;
        end
      end
      ST_DEC: begin
        if (n_q > match_q) begin
          match_d = n_q;
          mpos_d  = jn_q;
        end
        if (cneg_q) begin
          slot_d  = {2'b00, jn_q};
          k_d     = n_q;
          state_d = ST_GET;
        end else if (cpos_q) begin
          slot_d  = {2'b01, jn_q};
          l_d     = n_q;
          state_d = ST_GET;
        end else begin
          // equal string: the new node takes the old one's place
          sp_en   = 1'b1;
          sp_node = {1'b0, jn_q};
          sp_code = lzsst_pkg::NoLink;
          lc_ra   = jn_q;
          rc_ra   = jn_q;
          state_d = ST_EQ1;
        end
      end
      ST_EQ1: begin
        sp_en   = 1'b1;
        sp_node = lc_rd_q;
        sp_code = {2'b00, wi_q};
        lc_we   = 1'b1;
        lc_wd   = lc_rd_q;
        rc_we   = 1'b1;
        rc_wd   = rc_rd_q;
        zr_d    = rc_rd_q;
        state_d = ST_EQ2;
      end
      ST_EQ2: begin
        sp_en   = 1'b1;
        sp_node = zr_q;
        sp_code = {2'b01, wi_q};
        state_d = ST_INSEND;
      end
      ST_INSEND: begin
        sp_en   = 1'b1;
        sw_en   = 1'b1;
        state_d = ST_POST;
      end
      ST_POST: begin
        run_d = run_n;
        lit_d = match_q < 5'(lzsst_pkg::MinMatch);
        if (take) begin
          if (match_q < 5'(lzsst_pkg::MinMatch)) begin
            pend_d = pend2 - 7'sd1;
          end else begin
            pend_d = pend2 - $signed({2'b00, match_q});
          end
          state_d = ST_TOK;
        end else begin
          pend_d  = pend2;
          state_d = ST_NEXT;
        end
      end
      ST_TOK: begin
        cmd_valid_o = 1'b1;
        if (lit_q) begin
          cmd_o.kind = lzsst_pkg::TK_LIT;
        end else begin
          cmd_o.kind = lzsst_pkg::TK_MATCH;
          cmd_o.b0   = mpos_q[7:0];
          cmd_o.b1   = {mpos_q[11:8], 4'(match_q - 5'(lzsst_pkg::MinMatch))};
        end
        if (cmd_ready_i) state_d = ST_NEXT;
      end
      ST_NEXT: begin
        wi_d = wi_q + 12'd1;
        if (eof_q) begin
          if (pend_q > 7'sd0 && g_q < 5'(lzsst_pkg::MaxMatch + 1)) begin
            g_d     = g_q + 5'd1;
            state_d = ST_RM0;
          end else begin
            state_d = ST_CLOSE;
          end
        end else if (end_q) begin
          eof_d   = 1'b1;
          g_d     = '0;
          byte_d  = lzsst_pkg::FillByte;
          state_d = ST_RM0;
        end else begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          if (end_q) begin
            filling_d = 1'b1;
            look_d    = '0;
            wi_d      = 12'(lzsst_pkg::FillStart);
            run_d     = '0;
            pend_d    = '0;
            eof_d     = 1'b0;
            clr_d     = '0;
            state_d   = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    if (sw_en) begin
      if (sw_code[13:12] == 2'b00) begin
        lc_we = 1'b1;
        lc_wa = sw_code[11:0];
        lc_wd = sw_val;
      end else if (sw_code[13:12] == 2'b01) begin
        rc_we = 1'b1;
        rc_wa = sw_code[11:0];
        rc_wd = sw_val;
      end else if (sw_code[13:8] == 6'b100000) begin
        rt_we = 1'b1;
        rt_wa = sw_code[7:0];
        rt_wd = sw_val;
      end
    end
    if (sp_en && !sp_node[12]) begin
      pl_we = 1'b1;
      pl_wa = sp_node[11:0];
      pl_wd = sp_code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_we) wb_mem[wb_wa] <= wb_wd;
    wb_rd0_q <= wb_mem[wb_ra0];
    wb_rd1_q <= wb_mem[wb_ra1];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    pl_rd_q <= pl_mem[pl_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lc_we) lc_mem[lc_wa] <= lc_wd;
    lc_rd_q <= lc_mem[lc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rc_we) rc_mem[rc_wa] <= rc_wd;
    rc_rd_q <= rc_mem[rc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) rt_mem[rt_wa] <= rt_wd;
    rt_rd_q <= rt_mem[rt_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      filling_q <= 1'b1;
      look_q    <= '0;
      wi_q      <= 12'(lzsst_pkg::FillStart);
      run_q     <= '0;
      pend_q    <= '0;
      eof_q     <= 1'b0;
      end_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      filling_q <= filling_d;
      look_q    <= look_d;
      wi_q      <= wi_d;
      run_q     <= run_d;
      pend_q    <= pend_d;
      eof_q     <= eof_d;
      end_q     <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    g_q     <= g_d;
    z_q     <= z_d;
    zpar_q  <= zpar_d;
    zl_q    <= zl_d;
    zr_q    <= zr_d;
    j_q     <= j_d;
    moved_q <= moved_d;
    jp_q    <= jp_d;
    jl_q    <= jl_d;
    slot_q  <= slot_d;
    k_q     <= k_d;
    l_q     <= l_d;
    n_q     <= n_d;
    jn_q    <= jn_d;
    cneg_q  <= cneg_d;
    cpos_q  <= cpos_d;
    match_q <= match_d;
    mpos_q  <= mpos_d;
    lit_q   <= lit_d;
  end

endmodule

// ===== design/lzss_tree_compressor_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// input     in         in_valid_i / in_stall_o       in_data_i  (data_byte, end_of_data)
// output    out        out_valid_o / out_stall_i     out_data_o (out_byte, run_end, stream_end)
//
// The time a byte takes grows with each tree node visited and each byte compared, and
// with each level walked when a node leaves the window; the tree and window memory
// accesses set this. The last byte of a stream adds up to 18 such byte positions
// while the lookahead drains. After reset and after each stream end a clearing pass
// runs with in_stall_o high. Output bytes leave through a register and keep going
// while the input waits; a stalled output holds the core.

module lzss_tree_compressor_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lzsst_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lzsst_pkg::out_item_t out_data_o
);

  logic                in_ready;
  logic                cmd_valid;
  logic                cmd_ready;
  lzsst_pkg::tok_cmd_t cmd;

  assign in_stall_o = !in_ready;

  lzsst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  lzsst_group u_group (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
